// File: src/pbc_pkg.sv
// Shared types and codes for the PackBits compressor.
`timescale 1ns / 1ps
package pbc_pkg;

	localparam int STORE_DEPTH = 128;
	localparam int STORE_AW    = 7;

	// run count operations
	localparam logic [2:0] R_HOLD = 3'd0;
	localparam logic [2:0] R_INC  = 3'd1;
	localparam logic [2:0] R_DEC  = 3'd2;
	localparam logic [2:0] R_ZERO = 3'd3;
	localparam logic [2:0] R_LOAD = 3'd4;

	// literal count operations
	localparam logic [1:0] L_HOLD = 2'd0;
	localparam logic [1:0] L_PUSH = 2'd1;
	localparam logic [1:0] L_ZERO = 2'd2;

	// byte source for the packer
	localparam logic [2:0] E_NONE  = 3'd0;
	localparam logic [2:0] E_LHDR  = 3'd1;
	localparam logic [2:0] E_LBODY = 3'd2;
	localparam logic [2:0] E_RHDR  = 3'd3;
	localparam logic [2:0] E_RVAL  = 3'd4;

	typedef struct packed {
		logic       latch;
		logic [2:0] r_op;
		logic       v_zero;
		logic [1:0] l_op;
		logic [2:0] emit;
		logic       idx_clr;
		logic       idx_inc;
		logic       flush;
	} pbc_cmd_t;

	typedef struct packed {
		logic [7:0] run_cnt;
		logic [7:0] lit_cnt;
		logic       eq;
		logic       fin;
		logic       adv;
		logic       out_free;
		logic       pk_empty;
		logic       idx_last;
	} pbc_stat_t;

endpackage

// File: src/pbc_datapath.sv
// Datapath: run and literal state, literal memory, byte packer and output register.
`timescale 1ns / 1ps
module pbc_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  logic               final_byte,
	input  pbc_pkg::pbc_cmd_t  cmd,
	output pbc_pkg::pbc_stat_t st,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        out_bytes,
	output logic [3:0]         byte_count,
	output logic               burst_last,
	output logic               block_end
);

	logic [7:0]  b_q;
	logic        fin_q;
	logic [7:0]  v_q;
	logic [7:0]  r_q;
	logic [7:0]  l_q;
	logic [pbc_pkg::STORE_AW-1:0] idx_q;
	logic [pbc_pkg::STORE_AW-1:0] rd_addr;
	logic [7:0]  rd_q;
	logic [7:0]  store_q [pbc_pkg::STORE_DEPTH];

	logic [63:0] pk_word_q;
	logic [3:0]  pk_cnt_q;
	logic        out_valid_q;
	logic [63:0] out_word_q;
	logic [3:0]  out_cnt_q;
	logic        out_last_q;
	logic        out_end_q;

	logic [7:0]  ebyte;
	logic        emit_go;
	logic        adv;
	logic        out_free;
	logic        load_full;
	logic        load_flush;

	assign adv      = !(pk_cnt_q == 4'd8 && out_valid_q && !out_ready);
	assign out_free = !out_valid_q || out_ready;
	assign emit_go  = cmd.emit != pbc_pkg::E_NONE;
	assign load_full  = emit_go && pk_cnt_q == 4'd8;
	assign load_flush = cmd.flush && pk_cnt_q != 4'd0;

	always_comb begin
		unique case (cmd.emit)
			pbc_pkg::E_LHDR:  ebyte = l_q - 8'd1;
			pbc_pkg::E_LBODY: ebyte = rd_q;
			pbc_pkg::E_RHDR:  ebyte = 8'd1 - r_q;
			pbc_pkg::E_RVAL:  ebyte = v_q;
			default:          ebyte = 8'd0;
		endcase
	end

	always_comb begin
		priority if (cmd.idx_clr) begin
			rd_addr = '0;
		end else if (cmd.idx_inc) begin
			rd_addr = idx_q + 1'b1;
		end else begin
			rd_addr = idx_q;
		end
	end

	assign st.run_cnt  = r_q;
	assign st.lit_cnt  = l_q;
	assign st.eq       = b_q == v_q;
	assign st.fin      = fin_q;
	assign st.adv      = adv;
	assign st.out_free = out_free;
	assign st.pk_empty = pk_cnt_q == 4'd0;
	assign st.idx_last = idx_q == l_q[pbc_pkg::STORE_AW-1:0] - 1'b1;

	// input item, run and literal state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= 1'b0;
			v_q   <= 8'd0;
			r_q   <= 8'd0;
			l_q   <= 8'd0;
			idx_q <= '0;
		end else begin
			if (cmd.latch) begin
				fin_q <= final_byte;
			end
			unique case (cmd.r_op)
				pbc_pkg::R_INC:  r_q <= r_q + 8'd1;
				pbc_pkg::R_DEC:  r_q <= r_q - 8'd1;
				pbc_pkg::R_ZERO: r_q <= 8'd0;
				pbc_pkg::R_LOAD: begin
					r_q <= 8'd1;
					v_q <= b_q;
				end
				default: ;
			endcase
			if (cmd.v_zero) begin
				v_q <= 8'd0;
			end
			unique case (cmd.l_op)
				pbc_pkg::L_PUSH: l_q <= l_q + 8'd1;
				pbc_pkg::L_ZERO: l_q <= 8'd0;
				default: ;
			endcase
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			b_q <= data_byte;
		end
	end

	// literal memory
	always_ff @(posedge clk) begin
		if (cmd.l_op == pbc_pkg::L_PUSH) begin
			store_q[l_q[pbc_pkg::STORE_AW-1:0]] <= v_q;
		end
		rd_q <= store_q[rd_addr];
	end

	// byte packer; a full word is held until the next byte proves it is not the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_word_q <= 64'd0;
			pk_cnt_q  <= 4'd0;
		end else if (load_full) begin
			pk_word_q <= {56'd0, ebyte};
			pk_cnt_q  <= 4'd1;
		end else if (emit_go) begin
			pk_word_q[pk_cnt_q[2:0]*8 +: 8] <= ebyte;
			pk_cnt_q <= pk_cnt_q + 4'd1;
		end else if (load_flush) begin
			pk_word_q <= 64'd0;
			pk_cnt_q  <= 4'd0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_full || load_flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_full || load_flush) begin
			out_word_q <= pk_word_q;
			out_cnt_q  <= pk_cnt_q;
			out_last_q <= load_flush;
			out_end_q  <= load_flush && fin_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_bytes  = out_word_q;
	assign byte_count = out_cnt_q;
	assign burst_last = out_last_q;
	assign block_end  = out_end_q;

	a_pk_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pk_cnt_q <= 4'd8)
		else $error("packer count above eight");
	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_last_q |-> out_cnt_q == 4'd8)
		else $error("non-final word not full");
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_end_q |-> out_last_q && out_cnt_q != 4'd0)
		else $error("block end without burst end");

endmodule

// File: src/pbc_ctrl.sv
// Controller state machine that sequences runs, literals and word flushes.
`timescale 1ns / 1ps
module pbc_ctrl #(
	parameter int MAX_SEGMENT = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pbc_pkg::pbc_stat_t st,
	output pbc_pkg::pbc_cmd_t  cmd
);

	localparam logic [7:0] SEG = 8'(MAX_SEGMENT);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_LA    = 3'd2;
	localparam logic [2:0] S_LHDR  = 3'd3;
	localparam logic [2:0] S_LBODY = 3'd4;
	localparam logic [2:0] S_RHDR  = 3'd5;
	localparam logic [2:0] S_RVAL  = 3'd6;
	localparam logic [2:0] S_FLUSH = 3'd7;

	logic [2:0] state_q, state_d;
	logic       main_q, main_d;
	logic       fdone_q, fdone_d;
	logic       la_q, la_d;
	logic       new_q, new_d;
	logic [7:0] r;
	logic [7:0] l;

	assign r = st.run_cnt;
	assign l = st.lit_cnt;
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		main_d  = main_q;
		fdone_d = fdone_q;
		la_d    = la_q;
		new_d   = new_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					main_d    = 1'b0;
					fdone_d   = 1'b0;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				priority if (la_q) begin
					state_d = S_LA;
				end else if (main_q && r >= 8'd3 && r >= SEG) begin
					state_d = S_RHDR;
				end else if (!main_q) begin
					main_d = 1'b1;
					priority if (r >= 8'd3) begin
						if (st.eq) begin
							cmd.r_op = pbc_pkg::R_INC;
						end else begin
							new_d   = 1'b1;
							state_d = S_RHDR;
						end
					end else if (r != 8'd0 && st.eq) begin
						cmd.r_op = pbc_pkg::R_INC;
						// a run forms: flush the pending literal first
						if (r == 8'd2 && l != 8'd0) begin
							state_d = S_LHDR;
						end
					end else if (r != 8'd0) begin
						main_d  = 1'b0;
						la_d    = 1'b1;
						state_d = S_LA;
					end else begin
						cmd.r_op = pbc_pkg::R_LOAD;
					end
				end else if (st.fin && !fdone_q) begin
					priority if (r >= 8'd3) begin
						fdone_d = 1'b1;
						state_d = S_RHDR;
					end else if (r != 8'd0) begin
						la_d    = 1'b1;
						state_d = S_LA;
					end else begin
						fdone_d = 1'b1;
						if (l != 8'd0) begin
							state_d = S_LHDR;
						end
					end
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_LA: begin
				// move one lookahead byte into the literal
				cmd.l_op = pbc_pkg::L_PUSH;
				cmd.r_op = pbc_pkg::R_DEC;
				if (r == 8'd1) begin
					la_d = 1'b0;
				end
				priority if (l + 8'd1 >= SEG) begin
					state_d = S_LHDR;
				end else if (r == 8'd1) begin
					state_d = S_DISP;
				end else begin
					state_d = S_LA;
				end
			end
			S_LHDR: begin
				if (st.adv) begin
					cmd.emit    = pbc_pkg::E_LHDR;
					cmd.idx_clr = 1'b1;
					state_d     = S_LBODY;
				end
			end
			S_LBODY: begin
				if (st.adv) begin
					cmd.emit    = pbc_pkg::E_LBODY;
					cmd.idx_inc = 1'b1;
					if (st.idx_last) begin
						cmd.l_op = pbc_pkg::L_ZERO;
						state_d  = S_DISP;
					end
				end
			end
			S_RHDR: begin
				if (st.adv) begin
					cmd.emit = pbc_pkg::E_RHDR;
					state_d  = S_RVAL;
				end
			end
			S_RVAL: begin
				if (st.adv) begin
					cmd.emit = pbc_pkg::E_RVAL;
					cmd.r_op = new_q ? pbc_pkg::R_LOAD : pbc_pkg::R_ZERO;
					new_d    = 1'b0;
					state_d  = S_DISP;
				end
			end
			S_FLUSH: begin
				if (st.pk_empty || st.out_free) begin
					cmd.flush  = 1'b1;
					cmd.v_zero = st.fin;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			main_q  <= 1'b0;
			fdone_q <= 1'b0;
			la_q    <= 1'b0;
			new_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			main_q  <= main_d;
			fdone_q <= fdone_d;
			la_q    <= la_d;
			new_q   <= new_d;
		end
	end

	a_idle_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> r < SEG && l < SEG)
		else $error("segment limit reached between requests");
	a_la_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		la_q |-> r != 8'd0 && r < 8'd3)
		else $error("lookahead drain with bad run count");
	a_run_no_lit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && r >= 8'd3 |-> l == 8'd0)
		else $error("open run with pending literal");

endmodule

// File: src/packbits_compressor_core.sv
// Top level of the streaming PackBits compressor.
// Output: a full word leaves as the next byte enters the packer, the last word at the flush.
// Sequence: a request that sends nothing passes the accept, dispatch and flush states;
//   each emitted byte, lookahead move, further dispatch and output stall lengthens it, and
//   a new byte is accepted only back in the idle state.
// Reset: arst_n clears control, counts, packer and output valid, not the literal memory.
`timescale 1ns / 1ps
module packbits_compressor_core #(
	parameter int MAX_SEGMENT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_bytes,
	output logic [3:0]  byte_count,
	output logic        burst_last,
	output logic        block_end
);

	pbc_pkg::pbc_cmd_t  cmd;
	pbc_pkg::pbc_stat_t st;

	pbc_ctrl #(
		.MAX_SEGMENT(MAX_SEGMENT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	pbc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_bytes  (out_bytes),
		.byte_count (byte_count),
		.burst_last (burst_last),
		.block_end  (block_end)
	);

endmodule

// File: tb/packbits_checker.sv
// Scoreboard for the PackBits compressor: predicts coded words per request and compares them.
`timescale 1ns / 1ps
module packbits_checker #(
	parameter int MAX_SEGMENT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] out_bytes,
	input  logic [3:0]  byte_count,
	input  logic        burst_last,
	input  logic        block_end,
	output int          fail_count,
	output int          words_due
);

	localparam int SEG_LIMIT = (MAX_SEGMENT < 3) ? 3 :
		((MAX_SEGMENT > pbc_pkg::STORE_DEPTH) ? pbc_pkg::STORE_DEPTH : MAX_SEGMENT);

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        last;
		logic        blk_end;
	} code_word_t;

	logic [7:0] lit_bytes [pbc_pkg::STORE_DEPTH];
	int         lit_len;
	logic [7:0] rep_byte;
	int         rep_len;
	logic [7:0] burst_q [$];
	code_word_t coded_words [$];
	code_word_t want;

	task flush_literal();
		if (lit_len == 0)
			return;
		burst_q.push_back(8'(lit_len - 1));
		for (int i = 0; i < lit_len; i++)
			burst_q.push_back(lit_bytes[i]);
		lit_len = 0;
	endtask

	task flush_run();
		burst_q.push_back(8'(257 - rep_len));
		burst_q.push_back(rep_byte);
		rep_len = 0;
	endtask

	task grow_literal(input logic [7:0] b);
		lit_bytes[lit_len] = b;
		lit_len++;
		if (lit_len >= SEG_LIMIT)
			flush_literal();
	endtask

	// move undecided repeats into the literal
	task spill_lookahead();
		for (int k = 0; k < rep_len && k < 3; k++)
			grow_literal(rep_byte);
		rep_len = 0;
	endtask

	task encode_source_byte(input logic [7:0] b, input logic fin);
		code_word_t cw;
		int n;
		int nw;
		int cnt;
		burst_q.delete();
		if (rep_len >= 3) begin
			if (b == rep_byte) begin
				rep_len++;
				if (rep_len >= SEG_LIMIT)
					flush_run();
			end else begin
				flush_run();
				rep_byte = b;
				rep_len = 1;
			end
		end else if (rep_len > 0 && b == rep_byte) begin
			rep_len++;
			if (rep_len == 3) begin
				flush_literal();
				if (rep_len >= SEG_LIMIT)
					flush_run();
			end
		end else begin
			spill_lookahead();
			rep_byte = b;
			rep_len = 1;
		end
		if (fin) begin
			if (rep_len >= 3) begin
				flush_run();
			end else begin
				spill_lookahead();
				flush_literal();
			end
			rep_byte = 8'h00;
			rep_len = 0;
			lit_len = 0;
		end
		n = burst_q.size();
		nw = (n + 7) / 8;
		for (int w = 0; w < nw; w++) begin
			cnt = n - w * 8;
			if (cnt > 8)
				cnt = 8;
			cw.data = '0;
			for (int j = 0; j < cnt; j++)
				cw.data[8*j +: 8] = burst_q[w*8 + j];
			cw.count = 4'(cnt);
			cw.last = (w == nw - 1);
			cw.blk_end = fin && (w == nw - 1);
			coded_words.push_back(cw);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_len = 0;
			rep_byte = 8'h00;
			rep_len = 0;
			coded_words.delete();
			fail_count = 0;
			words_due = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (coded_words.size() == 0) begin
					$display("%0t: word with none expected: bytes %h count %0d last %b end %b",
						$time, out_bytes, byte_count, burst_last, block_end);
					fail_count++;
				end else begin
					want = coded_words.pop_front();
					if (out_bytes !== want.data) begin
						$display("%0t: out_bytes expected %h, actual %h",
							$time, want.data, out_bytes);
						fail_count++;
					end
					if (byte_count !== want.count) begin
						$display("%0t: byte_count expected %0d, actual %0d",
							$time, want.count, byte_count);
						fail_count++;
					end
					if (burst_last !== want.last) begin
						$display("%0t: burst_last expected %b, actual %b",
							$time, want.last, burst_last);
						fail_count++;
					end
					if (block_end !== want.blk_end) begin
						$display("%0t: block_end expected %b, actual %b",
							$time, want.blk_end, block_end);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				encode_source_byte(data_byte, final_byte);
			words_due = coded_words.size();
		end
	end

endmodule

// File: tb/testbench.sv
// Top of the PackBits compressor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_PER_PHASE = 35;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        final_byte;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        burst_last;
	logic        block_end;

	int         fail_count;
	int         words_due;
	int         tx_idle_pct = 6;
	int         rx_idle_pct = 55;
	int         stall_cycles = 0;
	int         sent_count = 0;
	logic [7:0] src_bytes [$];

	packbits_compressor_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_bytes  (out_bytes),
		.byte_count (byte_count),
		.burst_last (burst_last),
		.block_end  (block_end)
	);

	packbits_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_bytes  (out_bytes),
		.byte_count (byte_count),
		.burst_last (burst_last),
		.block_end  (block_end),
		.fail_count (fail_count),
		.words_due  (words_due)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// drop the run when neither side has moved a request for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic logic [7:0] pick_byte();
		logic [7:0] corner [4];
		corner = '{8'h00, 8'hFF, 8'h80, 8'h01};
		if ($urandom_range(0, 99) < 30)
			return corner[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent_count++;
	endtask

	// send the queued source bytes as one block, final flag on the last
	task automatic send_block();
		for (int i = 0; i < src_bytes.size(); i++)
			send_byte(src_bytes[i], i == src_bytes.size() - 1);
		src_bytes.delete();
	endtask

	task automatic add_run(input logic [7:0] v, input int n);
		repeat (n) src_bytes.push_back(v);
	endtask

	// bytes that differ from their neighbor, so no run forms
	task automatic add_literal(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			do b = pick_byte(); while (src_bytes.size() > 0 && b == src_bytes[$]);
			src_bytes.push_back(b);
		end
	endtask

	function automatic int pick_len();
		if ($urandom_range(0, 99) < 3)
			return $urandom_range(12, 40);
		return $urandom_range(1, 10);
	endfunction

	task automatic build_random_block();
		int segs;
		int kind;
		segs = $urandom_range(1, 6);
		for (int s = 0; s < segs; s++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40)
				add_run(pick_byte(), pick_len());
			else if (kind < 80)
				add_literal(pick_len());
			else
				repeat ($urandom_range(1, 12)) src_bytes.push_back(8'($urandom_range(0, 3)));
		end
	endtask

	initial begin
		int start;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		final_byte = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 6;
					rx_idle_pct = 55;
				end
				1: begin
					tx_idle_pct = 55;
					rx_idle_pct = 6;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			if (phase == 0) begin
				// one-byte blocks at both data extremes
				src_bytes = {8'h00};
				send_block();
				src_bytes = {8'hFF};
				send_block();
				// two repeats at end of block fall into the literal
				src_bytes = {8'hA5, 8'hA5};
				send_block();
				src_bytes = {8'h11, 8'h11, 8'h11};
				send_block();
				// literal flushed by a triple, run closed by a new byte
				src_bytes = {8'h01, 8'h02, 8'h03, 8'h03, 8'h03, 8'h04};
				send_block();
				src_bytes = {8'h55, 8'h55, 8'h7E};
				send_block();
				src_bytes = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
				send_block();
			end
			start = sent_count;
			while (sent_count - start < RANDOM_PER_PHASE) begin
				build_random_block();
				send_block();
			end
		end
		in_valid <= 1'b0;

		while (words_due != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
